// ----- src/riv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record image validator package
// Shared beat types, status codes and image constants.
// ----------------------------------------------------------------------------
package riv_pkg;

  // Status codes reported at the end of a check.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MAGIC     = 3'd1;
  localparam logic [2:0] ST_VERSION   = 3'd2;
  localparam logic [2:0] ST_COUNT     = 3'd3;
  localparam logic [2:0] ST_IMAGE_CRC = 3'd4;
  localparam logic [2:0] ST_REC_CRC   = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;

  localparam logic [31:0] IMAGE_MAGIC        = 32'h5245_4330;
  localparam logic [15:0] IMAGE_VERSION      = 16'd1;
  localparam logic [15:0] POLY16             = 16'h1021;
  localparam logic [31:0] POLY32             = 32'hEDB8_8320;
  localparam logic [15:0] CRC16_INIT         = 16'hFFFF;
  localparam logic [31:0] CRC32_INIT         = 32'hFFFF_FFFF;
  localparam logic [15:0] ACCEPT_LIMIT_RESET = 16'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } riv_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] record_count;
    logic [31:0] image_crc;
  } riv_out_t;

  // Command passed from the front end to the CRC back end.
  typedef struct packed {
    logic        is_report;   // report status directly, no CRC work
    logic [2:0]  status;
    logic [7:0]  data;
    logic        img_start;   // first record byte of the image
    logic        crc_lo;      // low byte of the record CRC field
    logic        crc_hi;      // high byte of the record CRC field
    logic        rec_end;     // final byte of a record
    logic        img_end;     // final byte of the image
    logic [31:0] stored_crc;
    logic [15:0] count;
  } riv_cmd_t;

endpackage
`default_nettype wire

// ----- src/record_image_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record image validator
// Checks a stored record image streamed one byte per beat: header fields,
// image CRC-32 and per-record CRC-16-CCITT, and reports one status per image.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                     Direction  Beat
//   item      push, full, item_i        in         one image byte with flags
//   result    empty, pop, result_o      out        status, count, image CRC
//   config    cfg_we_i, cfg_data_i      in         accept_limit register
//
// The block takes one byte per cycle while full is low. The front end
// classifies each byte and decides header faults and truncation; the back end
// runs both CRC updates for a byte combinationally, so a two-entry command
// queue between them and a two-entry result queue sustain one beat per clock.
// Between a byte and its result lie the command queue and the result queue.
// Reset leaves the block idle, waiting for a first byte, with accept_limit
// at 32 and the kept image CRC at zero.
// full rises only when the command queue holds two commands, which happens
// when the result side is not popped; header bytes without a fault issue no
// command at all.
// ----------------------------------------------------------------------------
module record_image_validator import riv_pkg::*; #(
  parameter int unsigned MAX_RECORDS      = 32,
  parameter int unsigned RECORD_BYTES     = 16,
  parameter int unsigned CRC_FIELD_OFFSET = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire riv_in_t     item_i,
  output logic             empty,
  input  wire logic        pop,
  output riv_out_t         result_o
);

  localparam int unsigned CmdW = $bits(riv_cmd_t);
  localparam int unsigned ResW = $bits(riv_out_t);

  logic     take;
  logic     cmd_push, cmd_full, cmd_empty, cmd_pop;
  riv_cmd_t cmd_in, cmd_out;
  logic     res_push, res_full;
  riv_out_t res_in;

  // The front end only ever pushes on an accepted byte, so gating the input
  // on a full command queue is enough to keep every command.
  assign full = cmd_full;
  assign take = push && !full;

  riv_front #(
    .MAX_RECORDS      (MAX_RECORDS),
    .RECORD_BYTES     (RECORD_BYTES),
    .CRC_FIELD_OFFSET (CRC_FIELD_OFFSET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  riv_fifo #(
    .Width (CmdW),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  riv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  riv_fifo #(
    .Width (ResW),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  // A command is only issued for a byte that was actually accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> take)
    else $error("command issued without an accepted byte");

  // The back end never drops a result into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // A successful check always reports a non-zero record count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_OK) |-> (result_o.record_count != 16'd0))
    else $error("successful result with zero record count");

  // Any failing status reports a zero record count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status != ST_OK) |-> (result_o.record_count == 16'd0))
    else $error("failing result with a record count");

endmodule
`default_nettype wire

// ----- src/riv_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record image validator queue
// Small synchronous FIFO built from registers.
// ----------------------------------------------------------------------------
module riv_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/riv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record image validator front end
// Tracks the image layout, checks the header and issues per-byte commands.
// ----------------------------------------------------------------------------
module riv_front import riv_pkg::*; #(
  parameter int unsigned MAX_RECORDS      = 32,
  parameter int unsigned RECORD_BYTES     = 16,
  parameter int unsigned CRC_FIELD_OFFSET = 12
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic      take_i,
  input  wire riv_in_t   item_i,
  output logic           cmd_push_o,
  output riv_cmd_t       cmd_o
);

  localparam int unsigned RcW = $clog2(MAX_RECORDS + 1);
  localparam logic [7:0]  LastIdx  = 8'(RECORD_BYTES - 1);
  localparam logic [7:0]  LoIdx    = 8'(CRC_FIELD_OFFSET);
  localparam logic [7:0]  HiIdx    = 8'(CRC_FIELD_OFFSET + 1);
  localparam logic [15:0] MaxCount = 16'(MAX_RECORDS);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_REC  = 2'd2;

  logic [1:0]     phase_q, phase_d;
  logic [3:0]     pos_q, pos_d;
  logic [7:0]     idx_q, idx_d;
  logic [RcW-1:0] done_q, done_d;
  logic [15:0]    limit_q;
  logic [31:0]    magic_q, magic_d;
  logic [15:0]    version_q, version_d;
  logic [15:0]    count_q, count_d;
  logic [31:0]    crc_q, crc_d;

  logic           in_hdr, in_rec;
  logic [3:0]     pos;
  logic [15:0]    count_full;
  logic [RcW-1:0] done_inc;
  logic           rec_end, img_end;

  assign pos        = item_i.first_byte ? 4'd0 : pos_q;
  assign in_hdr     = item_i.first_byte || (phase_q == PH_HDR);
  assign in_rec     = !item_i.first_byte && (phase_q == PH_REC);
  assign count_full = {item_i.data_byte, count_q[7:0]};
  assign done_inc   = done_q + 1'b1;
  assign rec_end    = (idx_q == LastIdx);
  assign img_end    = rec_end && (16'(done_inc) == count_q);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    done_d     = done_q;
    magic_d    = magic_q;
    version_d  = version_q;
    count_d    = count_q;
    crc_d      = crc_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.data       = item_i.data_byte;
    cmd_o.stored_crc = crc_q;
    cmd_o.count      = count_q;

    if (take_i && in_hdr) begin
      priority if (pos < 4'd4) begin
        magic_d[8*pos[1:0] +: 8] = item_i.data_byte;
      end else if (pos < 4'd6) begin
        version_d[8*pos[0] +: 8] = item_i.data_byte;
      end else if (pos < 4'd8) begin
        count_d[8*pos[0] +: 8] = item_i.data_byte;
      end else if (pos < 4'd12) begin
        crc_d[8*pos[1:0] +: 8] = item_i.data_byte;
      end else begin
        // sequence word is not used
      end

      phase_d = PH_HDR;
      pos_d   = pos + 1'b1;
      if (pos == 4'd15) begin
        phase_d = PH_REC;
        idx_d   = '0;
        done_d  = '0;
      end

      if (pos == 4'd7 && magic_q != IMAGE_MAGIC) begin
        cmd_push_o      = 1'b1;
        cmd_o.is_report = 1'b1;
        cmd_o.status    = ST_MAGIC;
        phase_d         = PH_IDLE;
      end else if (pos == 4'd7 && version_q != IMAGE_VERSION) begin
        cmd_push_o      = 1'b1;
        cmd_o.is_report = 1'b1;
        cmd_o.status    = ST_VERSION;
        phase_d         = PH_IDLE;
      end else if (pos == 4'd7 && (count_full == '0 || count_full > MaxCount ||
                                   count_full > limit_q)) begin
        cmd_push_o      = 1'b1;
        cmd_o.is_report = 1'b1;
        cmd_o.status    = ST_COUNT;
        phase_d         = PH_IDLE;
      end else if (item_i.last_byte) begin
        cmd_push_o      = 1'b1;
        cmd_o.is_report = 1'b1;
        cmd_o.status    = ST_TRUNC;
        phase_d         = PH_IDLE;
      end
    end else if (take_i && in_rec) begin
      cmd_push_o = 1'b1;
      if (item_i.last_byte && !img_end) begin
        cmd_o.is_report = 1'b1;
        cmd_o.status    = ST_TRUNC;
        phase_d         = PH_IDLE;
      end else begin
        cmd_o.img_start = (idx_q == '0) && (done_q == '0);
        cmd_o.crc_lo    = (idx_q == LoIdx);
        cmd_o.crc_hi    = (idx_q == HiIdx);
        cmd_o.rec_end   = rec_end;
        cmd_o.img_end   = img_end;
        if (img_end) begin
          phase_d = PH_IDLE;
        end else if (rec_end) begin
          idx_d  = '0;
          done_d = done_inc;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      idx_q   <= '0;
      done_q  <= '0;
      limit_q <= ACCEPT_LIMIT_RESET;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    magic_q   <= magic_d;
    version_q <= version_d;
    count_q   <= count_d;
    crc_q     <= crc_d;
  end

endmodule
`default_nettype wire

// ----- src/riv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record image validator back end
// Runs the image CRC-32 and record CRC-16 and forms the final status.
// ----------------------------------------------------------------------------
module riv_back import riv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  wire riv_cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  wire logic     res_full_i,
  output logic          res_push_o,
  output riv_out_t      res_o
);

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ POLY32) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ POLY16) : (c << 1);
    end
    return c;
  endfunction

  logic [31:0] crc32_q, crc32_d;
  logic [15:0] crc16_q, crc16_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;
  logic        fail_q, fail_d;
  logic [31:0] last_crc_q, last_crc_d;

  logic [31:0] c32_in, c32_new;
  logic [15:0] c16_in, c16_new;
  logic [7:0]  lo_in, hi_in, masked;
  logic        fail_in, rec_fail;

  assign cmd_pop_o = cmd_valid_i && !res_full_i;

  always_comb begin
    c32_in  = cmd_i.img_start ? CRC32_INIT : crc32_q;
    c16_in  = cmd_i.img_start ? CRC16_INIT : crc16_q;
    lo_in   = cmd_i.img_start ? 8'd0 : lo_q;
    hi_in   = cmd_i.img_start ? 8'd0 : hi_q;
    fail_in = cmd_i.img_start ? 1'b0 : fail_q;
    masked  = (cmd_i.crc_lo || cmd_i.crc_hi) ? 8'd0 : cmd_i.data;
    c32_new = crc32_byte(c32_in, cmd_i.data);
    c16_new = crc16_byte(c16_in, masked);
    lo_d    = cmd_i.crc_lo ? cmd_i.data : lo_in;
    hi_d    = cmd_i.crc_hi ? cmd_i.data : hi_in;
    rec_fail = fail_in || (c16_new != {hi_d, lo_d});

    crc32_d    = c32_new;
    crc16_d    = c16_new;
    fail_d     = fail_in;
    last_crc_d = last_crc_q;
    if (cmd_i.rec_end) begin
      fail_d  = rec_fail;
      crc16_d = CRC16_INIT;
      lo_d    = 8'd0;
      hi_d    = 8'd0;
    end

    res_push_o         = 1'b0;
    res_o.status       = cmd_i.status;
    res_o.record_count = 16'd0;
    if (cmd_pop_o && cmd_i.is_report) begin
      res_push_o = 1'b1;
    end else if (cmd_pop_o && cmd_i.img_end) begin
      res_push_o = 1'b1;
      priority if (~c32_new != cmd_i.stored_crc) begin
        res_o.status = ST_IMAGE_CRC;
      end else if (rec_fail) begin
        res_o.status = ST_REC_CRC;
      end else begin
        res_o.status       = ST_OK;
        res_o.record_count = cmd_i.count;
        last_crc_d         = cmd_i.stored_crc;
      end
    end
    res_o.image_crc = last_crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc32_q    <= CRC32_INIT;
      crc16_q    <= CRC16_INIT;
      lo_q       <= '0;
      hi_q       <= '0;
      fail_q     <= 1'b0;
      last_crc_q <= '0;
    end else if (cmd_pop_o) begin
      if (!cmd_i.is_report) begin
        crc32_q <= crc32_d;
        crc16_q <= crc16_d;
        lo_q    <= lo_d;
        hi_q    <= hi_d;
        fail_q  <= fail_d;
      end
      last_crc_q <= last_crc_d;
    end
  end

endmodule
`default_nettype wire
